[src/psf2_pkg.sv]
// Package for the PSF2 unicode table parser.
// Holds widths, marker bytes, event codes, state enums and shared structs.
// It depends on nothing else.
package psf2_pkg;

	localparam int BYTE_W          = 8;
	localparam int CP_W            = 21;
	localparam int OFF_W           = 32;
	localparam int GB_W            = 16;
	localparam int TABLE_DEPTH_DEF = 512;

	localparam logic [GB_W-1:0]   GLYPH_BYTES_RST = GB_W'(16);
	localparam logic [BYTE_W-1:0] MARK_STOP       = 8'hFE;
	localparam logic [BYTE_W-1:0] MARK_SEP        = 8'hFF;
	localparam logic [CP_W-1:0]   CP_MAX          = 21'h10FFFF;

	// Event codes on the output channel
	typedef enum logic [2:0] {
		EV_NEW     = 3'd0,
		EV_INVALID = 3'd1,
		EV_REDEF   = 3'd2,
		EV_STOP    = 3'd3,
		EV_FULL    = 3'd4
	} evt_kind_t;

	// Top level control
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} ctl_state_t;

	// Duplicate scan control
	typedef enum logic {
		SC_IDLE,
		SC_SCAN
	} scan_state_t;

	// Decoder verdict for the byte on the input channel
	typedef struct packed {
		logic             has_res;
		logic             search;
		evt_kind_t        kind;
		logic [CP_W-1:0]  cp;
		logic [OFF_W-1:0] offset;
	} dec_out_t;

	// Request into the seen table
	typedef struct packed {
		logic            start;
		logic            clear;
		logic [CP_W-1:0] cp;
	} scan_req_t;

	// Answer from the seen table
	typedef struct packed {
		logic      done;
		evt_kind_t kind;
	} scan_rsp_t;

endpackage

[src/psf2_in_if.sv]
// Input channel: one unicode table byte per request.
// Depends on psf2_pkg.
interface psf2_in_if
	import psf2_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] table_byte;
	logic              first_byte;

	modport source (output valid, output table_byte, output first_byte, input ready);
	modport sink   (input valid, input table_byte, input first_byte, output ready);
endinterface

[src/psf2_out_if.sv]
// Output channel: one parser event per request.
// Depends on psf2_pkg.
interface psf2_out_if
	import psf2_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [2:0]       event_kind;
	logic [CP_W-1:0]  codepoint;
	logic [OFF_W-1:0] glyph_offset;

	modport source (output valid, output event_kind, output codepoint, output glyph_offset,
		input ready);
	modport sink   (input valid, input event_kind, input codepoint, input glyph_offset,
		output ready);
endinterface

[src/psf2_utf8_dec.sv]
// UTF-8 decoder, separator counter and glyph offset tracker.
// Holds pending bytes, offset, stop flag and the glyph_bytes register.
// Depends on psf2_pkg.
module psf2_utf8_dec
	import psf2_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [GB_W-1:0]   cfg_wdata,
	input  logic              accept,
	input  logic [BYTE_W-1:0] table_byte,
	input  logic              first_byte,
	output dec_out_t          dec
);

	logic [GB_W-1:0]   glyph_bytes_q;
	logic [BYTE_W-1:0] pend_q [3];
	logic [1:0]        pcnt_q;
	logic [OFF_W-1:0]  off_q;
	logic              stopped_q;

	// Effective state after an optional clear by first_byte
	logic [1:0]        pcnt_e;
	logic [OFF_W-1:0]  off_e;
	logic              stopped_e;

	logic [BYTE_W-1:0] b0, b1, b2, b3;
	logic [2:0]        len;
	logic [2:0]        pcnt_n;
	logic [OFF_W:0]    off_sum;
	logic [OFF_W-1:0]  off_adv;
	logic [CP_W-1:0]   v;
	logic              trail_ok;
	logic              min_ok;
	logic              seq_ok;

	logic [1:0]        pcnt_d;
	logic [OFF_W-1:0]  off_d;
	logic              stopped_d;
	logic              store_byte;

	assign pcnt_e    = first_byte ? 2'd0 : pcnt_q;
	assign off_e     = first_byte ? '0 : off_q;
	assign stopped_e = first_byte ? 1'b0 : stopped_q;
	assign pcnt_n    = {1'b0, pcnt_e} + 3'd1;

	// Sequence bytes with the incoming byte in its slot
	always_comb begin
		b0 = (pcnt_e == 2'd0) ? table_byte : pend_q[0];
		b1 = (pcnt_e == 2'd1) ? table_byte : pend_q[1];
		b2 = (pcnt_e == 2'd2) ? table_byte : pend_q[2];
		b3 = table_byte;
	end

	// Length from the lead byte, zero for a byte that starts nothing
	always_comb begin
		if (b0[7] == 1'b0)            len = 3'd1;
		else if (b0[7:5] == 3'b110)   len = 3'd2;
		else if (b0[7:4] == 4'b1110)  len = 3'd3;
		else if (b0[7:3] == 5'b11110) len = 3'd4;
		else                          len = 3'd0;
	end

	// Assemble and check a full sequence
	always_comb begin
		v        = '0;
		trail_ok = 1'b1;
		min_ok   = 1'b1;
		case (len)
			3'd1: begin
				v = CP_W'(b0[6:0]);
			end
			3'd2: begin
				v        = CP_W'({b0[4:0], b1[5:0]});
				trail_ok = (b1[7:6] == 2'b10);
				min_ok   = (v >= CP_W'(21'h80));
			end
			3'd3: begin
				v        = CP_W'({b0[3:0], b1[5:0], b2[5:0]});
				trail_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
				min_ok   = (v >= CP_W'(21'h800));
			end
			default: begin
				v        = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
				trail_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
				min_ok   = (v >= CP_W'(21'h10000));
			end
		endcase
		seq_ok = trail_ok && min_ok && !((v >= CP_W'(21'hD800)) && (v <= CP_W'(21'hDFFF)))
			&& (v <= CP_MAX);
	end

	// Saturating offset advance at a separator
	assign off_sum = {1'b0, off_e} + {{(OFF_W+1-GB_W){1'b0}}, glyph_bytes_q};
	assign off_adv = off_sum[OFF_W] ? '1 : off_sum[OFF_W-1:0];

	// Byte classification and next state
	always_comb begin
		dec.has_res = 1'b0;
		dec.search  = 1'b0;
		dec.kind    = EV_INVALID;
		dec.cp      = '0;
		dec.offset  = off_e;
		pcnt_d      = pcnt_e;
		off_d       = off_e;
		stopped_d   = stopped_e;
		store_byte  = 1'b0;
		if (stopped_e) begin
			pcnt_d = pcnt_e;
		end else if (table_byte == MARK_STOP) begin
			stopped_d   = 1'b1;
			pcnt_d      = 2'd0;
			dec.has_res = 1'b1;
			dec.kind    = EV_STOP;
		end else if (table_byte == MARK_SEP) begin
			pcnt_d      = 2'd0;
			off_d       = off_adv;
			dec.has_res = (pcnt_e != 2'd0);
			dec.kind    = EV_INVALID;
		end else if (len == 3'd0) begin
			pcnt_d      = 2'd0;
			dec.has_res = 1'b1;
			dec.kind    = EV_INVALID;
		end else if (pcnt_n < len) begin
			pcnt_d     = pcnt_n[1:0];
			store_byte = 1'b1;
		end else begin
			pcnt_d = 2'd0;
			if (seq_ok) begin
				dec.search = 1'b1;
				dec.cp     = v;
				dec.kind   = EV_NEW;
			end else begin
				dec.has_res = 1'b1;
				dec.kind    = EV_INVALID;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_bytes_q <= GLYPH_BYTES_RST;
			pcnt_q        <= 2'd0;
			off_q         <= '0;
			stopped_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				glyph_bytes_q <= cfg_wdata;
			end
			if (accept) begin
				pcnt_q    <= pcnt_d;
				off_q     <= off_d;
				stopped_q <= stopped_d;
			end
		end
	end

	// Partial sequence bytes
	always_ff @(posedge clk) begin
		if (accept && store_byte) begin
			pend_q[pcnt_e] <= table_byte;
		end
	end

endmodule

[src/psf2_seen_table.sv]
// Table of codepoints already mapped, with a sequential duplicate scan.
// One synchronous memory, one read per cycle, append at the fill count.
// Depends on psf2_pkg.
module psf2_seen_table
	import psf2_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_req_t req,
	output scan_rsp_t rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [CP_W-1:0]  mem [TABLE_DEPTH];
	logic [CP_W-1:0]  rd_data_s1;
	logic             cmp_vld_s1;

	scan_state_t      sc_q, sc_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CP_W-1:0]  cp_q;

	logic             issue;
	logic             hit;
	logic             full;
	logic             append;

	assign full = (count_q >= CNT_W'(TABLE_DEPTH));

	// Scan sequencer: read each stored entry, compare it in the next cycle
	always_comb begin
		sc_d     = sc_q;
		issue    = 1'b0;
		hit      = 1'b0;
		append   = 1'b0;
		rsp.done = 1'b0;
		rsp.kind = EV_NEW;
		unique case (sc_q)
			SC_IDLE: begin
				if (req.start) begin
					sc_d = SC_SCAN;
				end
			end
			SC_SCAN: begin
				hit = cmp_vld_s1 && (rd_data_s1 == cp_q);
				if (hit) begin
					rsp.done = 1'b1;
					rsp.kind = EV_REDEF;
					sc_d     = SC_IDLE;
				end else if (scan_idx_q == count_q) begin
					if (!cmp_vld_s1) begin
						rsp.done = 1'b1;
						rsp.kind = full ? EV_FULL : EV_NEW;
						append   = !full;
						sc_d     = SC_IDLE;
					end
				end else begin
					issue = 1'b1;
				end
			end
			default: begin
				sc_d = SC_IDLE;
			end
		endcase
	end

	// Sequencer registers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q       <= SC_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			sc_q       <= sc_d;
			cmp_vld_s1 <= issue;
			if (req.start) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (req.clear) begin
				count_q <= '0;
			end else if (append) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Codepoint under search
	always_ff @(posedge clk) begin
		if (req.start) begin
			cp_q <= req.cp;
		end
	end

	// Codepoint memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[scan_idx_q[IDX_W-1:0]];
		end
		if (append) begin
			mem[count_q[IDX_W-1:0]] <= cp_q;
		end
	end

endmodule

[src/psf2_unicode_table_parser_core.sv]
// PSF2 unicode table parser: UTF-8 decode, glyph offsets, duplicate check.
// Output valid comes from a register: a byte with an event goes to ST_EMIT; a completed codepoint
// goes first to ST_SEARCH, which reads the stored entries, one memory read per cycle, until a match.
// Throughput: one byte per cycle when no event results; an event byte holds the input until
// it is in the output register; ST_EMIT waits while an untaken event holds the output register.
// Async reset clears control state and glyph_bytes to 16; the memory is tracked by a fill count.
module psf2_unicode_table_parser_core
	import psf2_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [GB_W-1:0] cfg_wdata,
	psf2_in_if.sink         in_ch,
	psf2_out_if.source      out_ch
);

	ctl_state_t       st_q, st_d;
	dec_out_t         dec;
	scan_req_t        sreq;
	scan_rsp_t        srsp;
	logic             in_acc;
	logic             out_load;

	evt_kind_t        res_kind_q;
	logic [CP_W-1:0]  res_cp_q;
	logic [OFF_W-1:0] res_off_q;

	logic             out_valid_q;
	evt_kind_t        out_kind_q;
	logic [CP_W-1:0]  out_cp_q;
	logic [OFF_W-1:0] out_off_q;

	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	psf2_utf8_dec u_dec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (in_acc),
		.table_byte (in_ch.table_byte),
		.first_byte (in_ch.first_byte),
		.dec        (dec)
	);

	assign sreq.start = in_acc && dec.search;
	assign sreq.clear = in_acc && in_ch.first_byte;
	assign sreq.cp    = dec.cp;

	psf2_seen_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	// Control: take a byte, wait for the search, hand the event to the output
	always_comb begin
		st_d     = st_q;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_acc && dec.search) begin
					st_d = ST_SEARCH;
				end else if (in_acc && dec.has_res) begin
					st_d = ST_EMIT;
				end
			end
			ST_SEARCH: begin
				if (srsp.done) begin
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending result and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_kind_q <= dec.kind;
			res_cp_q   <= dec.cp;
			res_off_q  <= dec.offset;
		end else if ((st_q == ST_SEARCH) && srsp.done) begin
			res_kind_q <= srsp.kind;
		end
		if (out_load) begin
			out_kind_q <= res_kind_q;
			out_cp_q   <= res_cp_q;
			out_off_q  <= res_off_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_kind   = out_kind_q;
	assign out_ch.codepoint    = out_cp_q;
	assign out_ch.glyph_offset = out_off_q;

endmodule
